>>> rtl/todi_pkg.sv
// Shared types, register map, constants and arithmetic helpers for the odometry integrator.
package todi_pkg;

  // Register map: index of each configuration register.
  typedef enum logic [2:0] {
    REG_LEFT_SCALE  = 3'd0,
    REG_RIGHT_SCALE = 3'd1,
    REG_YAW_GAIN    = 3'd2,
    REG_A_VX_SPEED  = 3'd3,
    REG_A_VX_TURN   = 3'd4,
    REG_A_VY_TURN   = 3'd5,
    REG_A_YAW_SPEED = 3'd6,
    REG_A_YAW_TURN  = 3'd7
  } reg_idx_e;

  localparam logic [31:0] RstLeftScale  = 32'd1149597;
  localparam logic [31:0] RstRightScale = 32'd1149510;
  localparam logic [31:0] RstYawGain    = 32'd23072900;
  localparam logic [31:0] RstAVxSpeed   = 32'd31675;
  localparam logic [31:0] RstAVxTurn    = 32'd93952410;
  localparam logic [31:0] RstAVyTurn    = 32'd40265318;
  localparam logic [31:0] RstAYawSpeed  = 32'd20428;
  localparam logic [31:0] RstAYawTurn   = 32'd2416;

  typedef struct packed {
    logic [31:0]        left_scale;
    logic [31:0]        right_scale;
    logic [31:0]        yaw_gain;
    logic signed [31:0] a_vx_speed;
    logic signed [31:0] a_vx_turn;
    logic signed [31:0] a_vy_turn;
    logic signed [31:0] a_yaw_speed;
    logic signed [31:0] a_yaw_turn;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] left_rpm;
    logic signed [15:0] right_rpm;
    logic [19:0]        elapsed;
    logic               zero_dt;
  } item_t;

  typedef struct packed {
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic [31:0]        heading;
    logic signed [31:0] lin_vel;
    logic signed [31:0] yaw_rate;
    logic [47:0]        var_x;
    logic [47:0]        var_y;
    logic [47:0]        twist_var_vx;
    logic [47:0]        twist_var_vy;
    logic [47:0]        twist_var_yaw;
    logic signed [47:0] joint_left;
    logic signed [47:0] joint_right;
  } result_t;

  // Multiplier: 48-bit signed A by 36-bit signed B, taken in two 24-bit halves of A.
  localparam int unsigned OpAW = 48;
  localparam int unsigned OpBW = 36;
  localparam int unsigned HalfW = 24;
  localparam int unsigned ProdW = 84;
  typedef logic signed [ProdW-1:0] prod_t;

  typedef struct packed {
    logic lo;   // first partial product, loads the accumulator
    logic hi;   // second partial product, adds in the upper half
  } mul_ctl_t;

  // Fixed constants
  localparam logic signed [35:0] InvTwoPiQ32 = 36'sd683565276;
  localparam logic signed [35:0] HalfPiQ30   = 36'sd1686629713;
  localparam logic signed [35:0] PiOver30Q32 = 36'sd449767923;
  localparam prod_t OneQ30    = prod_t'(64'sd1073741824);
  localparam prod_t OfsVx     = prod_t'(64'sd32212);
  localparam prod_t OfsYaw    = prod_t'(64'sd1342);
  localparam logic signed [31:0] SlowQ24 = 32'sd83886;
  localparam logic [47:0] FloorQ32 = 48'd429497;
  localparam prod_t Max48U    = prod_t'(65'sh0_FFFF_FFFF_FFFF);

  // Reciprocals for exact floor division of values below 2^31:
  // m = ceil(2^(31+l) / d), quotient = (n * m) >> (31 + l), l = ceil(log2 d).
  localparam logic [35:0] DivM72 = 36'(((64'd1 << 38) + 64'd71) / 64'd72);
  localparam logic [35:0] DivM42 = 36'(((64'd1 << 37) + 64'd41) / 64'd42);
  localparam logic [35:0] DivM20 = 36'(((64'd1 << 36) + 64'd19) / 64'd20);
  localparam logic [35:0] DivM6  = 36'(((64'd1 << 34) + 64'd5)  / 64'd6);
  localparam logic [35:0] DivM90 = 36'(((64'd1 << 38) + 64'd89) / 64'd90);
  localparam logic [35:0] DivM56 = 36'(((64'd1 << 37) + 64'd55) / 64'd56);
  localparam logic [35:0] DivM30 = 36'(((64'd1 << 36) + 64'd29) / 64'd30);
  localparam logic [35:0] DivM12 = 36'(((64'd1 << 35) + 64'd11) / 64'd12);

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL1,
    B_MUL2,
    B_WB,
    B_OUT
  } bstate_e;

  // Micro-steps of the back end, in execution order.
  typedef enum logic [5:0] {
    S_VL, S_VR, S_W,
    S_E1, S_E2, S_E3, S_E4, S_E5,
    S_B1, S_B2, S_B3,
    S_RATE, S_DYAW, S_X, S_X2,
    S_SD72, S_SM42, S_SD42, S_SM20, S_SD20, S_SM6, S_SD6, S_SIN,
    S_CD90, S_CM56, S_CD56, S_CM30, S_CD30, S_CM12, S_CD12, S_COS,
    S_DIST, S_PX, S_PY,
    S_JL1, S_JL2, S_JR1, S_JR2,
    S_VX, S_VY
  } step_e;

  // Round half up then floor shift.
  function automatic prod_t rnd(input prod_t p, input int unsigned n);
    prod_t half;
    half = prod_t'(1) <<< (n - 1);
    return (p + half) >>> n;
  endfunction

  function automatic logic signed [31:0] sat32(input prod_t v);
    logic signed [31:0] r;
    if (v > prod_t'(64'sd2147483647)) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < prod_t'(-64'sd2147483648)) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input prod_t v);
    logic signed [47:0] r;
    if (v > prod_t'(64'sh7FFF_FFFF_FFFF)) begin
      r = 48'sh7FFF_FFFF_FFFF;
    end else if (v < prod_t'(-64'sh8000_0000_0000)) begin
      r = 48'sh8000_0000_0000;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/todi_regs.sv
// APB-style configuration register file.
module todi_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output todi_pkg::cfg_t     cfg_o
);
  import todi_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_scale  <= RstLeftScale;
      cfg_q.right_scale <= RstRightScale;
      cfg_q.yaw_gain    <= RstYawGain;
      cfg_q.a_vx_speed  <= RstAVxSpeed;
      cfg_q.a_vx_turn   <= RstAVxTurn;
      cfg_q.a_vy_turn   <= RstAVyTurn;
      cfg_q.a_yaw_speed <= RstAYawSpeed;
      cfg_q.a_yaw_turn  <= RstAYawTurn;
    end else if (wr_en) begin
      case (idx)
        REG_LEFT_SCALE:  cfg_q.left_scale  <= pwdata;
        REG_RIGHT_SCALE: cfg_q.right_scale <= pwdata;
        REG_YAW_GAIN:    cfg_q.yaw_gain    <= pwdata;
        REG_A_VX_SPEED:  cfg_q.a_vx_speed  <= pwdata;
        REG_A_VX_TURN:   cfg_q.a_vx_turn   <= pwdata;
        REG_A_VY_TURN:   cfg_q.a_vy_turn   <= pwdata;
        REG_A_YAW_SPEED: cfg_q.a_yaw_speed <= pwdata;
        REG_A_YAW_TURN:  cfg_q.a_yaw_turn  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LEFT_SCALE:  prdata = cfg_q.left_scale;
      REG_RIGHT_SCALE: prdata = cfg_q.right_scale;
      REG_YAW_GAIN:    prdata = cfg_q.yaw_gain;
      REG_A_VX_SPEED:  prdata = cfg_q.a_vx_speed;
      REG_A_VX_TURN:   prdata = cfg_q.a_vx_turn;
      REG_A_VY_TURN:   prdata = cfg_q.a_vy_turn;
      REG_A_YAW_SPEED: prdata = cfg_q.a_yaw_speed;
      REG_A_YAW_TURN:  prdata = cfg_q.a_yaw_turn;
      default:         prdata = '0;
    endcase
  end

endmodule

>>> rtl/todi_front.sv
// Input stage: takes items, tags zero-elapsed ones, hands them to the queue.
module todi_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [15:0]  left_rpm_i,
  input  logic signed [15:0]  right_rpm_i,
  input  logic [19:0]         elapsed_i,
  output logic                push_o,
  input  logic                q_ready_i,
  output todi_pkg::item_t     item_o
);
  import todi_pkg::*;

  logic  hold_valid_q, hold_valid_d;
  item_t hold_q;

  assign in_ready_o   = !hold_valid_q || q_ready_i;
  assign push_o       = hold_valid_q;
  assign item_o       = hold_q;
  assign hold_valid_d = in_ready_o ? in_valid_i : hold_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      hold_q.left_rpm  <= left_rpm_i;
      hold_q.right_rpm <= right_rpm_i;
      hold_q.elapsed   <= elapsed_i;
      hold_q.zero_dt   <= (elapsed_i == '0);
    end
  end

endmodule

>>> rtl/todi_fifo.sv
// Short item queue between front and back.
module todi_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            ready_o,
  input  todi_pkg::item_t item_i,
  output logic            valid_o,
  input  logic            pop_i,
  output todi_pkg::item_t item_o
);
  import todi_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  item_t            entry_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign item_o  = entry_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= bump(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= bump(rd_ptr_q);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= item_i;
  end

endmodule

>>> rtl/todi_mul.sv
// Signed multiplier, 48 x 36 bits, one 24-bit half of A per cycle.
module todi_mul (
  input  logic                                clk_i,
  input  todi_pkg::mul_ctl_t                  ctl_i,
  input  logic signed [todi_pkg::OpAW-1:0]    a_i,
  input  logic signed [todi_pkg::OpBW-1:0]    b_i,
  output todi_pkg::prod_t                     prod_o
);
  import todi_pkg::*;

  logic signed [HalfW+OpBW:0]   p_lo;
  logic signed [HalfW+OpBW-1:0] p_hi;
  prod_t prod_q, prod_d;

  assign p_lo = $signed({1'b0, a_i[HalfW-1:0]}) * b_i;
  assign p_hi = $signed(a_i[OpAW-1:HalfW]) * b_i;

  always_comb begin
    prod_d = prod_q;
    if (ctl_i.lo) begin
      prod_d = prod_t'(p_lo);
    end else if (ctl_i.hi) begin
      prod_d = prod_q + (prod_t'(p_hi) <<< HalfW);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

>>> rtl/todi_back.sv
// Back end: micro-step sequencer over the shared multiplier, state and result register.
module todi_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  todi_pkg::cfg_t    cfg_i,
  input  logic              item_valid_i,
  input  todi_pkg::item_t   item_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output todi_pkg::result_t result_o
);
  import todi_pkg::*;

  bstate_e state_q, state_d;
  step_e   step_q;
  logic    out_valid_q;
  logic    out_load, wb_en, last_step;
  mul_ctl_t mctl;

  logic signed [OpAW-1:0] op_a;
  logic signed [OpBW-1:0] op_b;
  prod_t p, r12, r20, r24, r30;

  // working values of the current item
  logic signed [15:0] rl_q, rr_q;
  logic [19:0]        e_q;
  logic               zero_q;
  logic signed [31:0] vl_q, v_q, dsat_q, w_q;
  logic signed [31:0] vr_w;
  logic signed [32:0] vsum;
  logic signed [41:0] rate_q;
  logic signed [30:0] a_q, x_q, x2_q, m_q;
  logic [1:0]         oct_q;
  logic signed [31:0] t_q, s_q, co_q, si_q, cval;
  logic signed [32:0] dist_q;
  logic signed [33:0] j_q;
  logic signed [39:0] et_q;
  logic signed [31:0] evx_q, evy_q, eyaw_q;
  logic [38:0]        bvx_q, bvy_q, byaw_q;
  logic [31:0]        yaw_new, yaw_sh;
  prod_t              sum_vx, sum_vy;

  // persistent state
  logic signed [47:0] xacc_q, yacc_q, lang_q, rang_q;
  logic [47:0]        varx_q, vary_q;
  logic [31:0]        yaw_q;

  result_t res_q;
  logic    slow_v, slow_w;

  todi_mul u_mul (
    .clk_i  (clk_i),
    .ctl_i  (mctl),
    .a_i    (op_a),
    .b_i    (op_b),
    .prod_o (p)
  );

  assign r12 = rnd(p, 12);
  assign r20 = rnd(p, 20);
  assign r24 = rnd(p, 24);
  assign r30 = rnd(p, 30);

  assign last_step = (step_q == S_VY) || ((step_q == S_B3) && zero_q);

  // operand selection per step
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step_q)
      S_VL:   begin op_a = OpAW'(rl_q);   op_b = $signed(OpBW'(cfg_i.left_scale));  end
      S_VR:   begin op_a = OpAW'(rr_q);   op_b = $signed(OpBW'(cfg_i.right_scale)); end
      S_W:    begin op_a = OpAW'(dsat_q); op_b = $signed(OpBW'(cfg_i.yaw_gain));    end
      S_E1:   begin op_a = OpAW'(cfg_i.a_vx_speed);  op_b = OpBW'(v_q); end
      S_E2:   begin op_a = OpAW'(cfg_i.a_vx_turn);   op_b = OpBW'(w_q); end
      S_E3:   begin op_a = OpAW'(cfg_i.a_vy_turn);   op_b = OpBW'(w_q); end
      S_E4:   begin op_a = OpAW'(cfg_i.a_yaw_speed); op_b = OpBW'(v_q); end
      S_E5:   begin op_a = OpAW'(cfg_i.a_yaw_turn);  op_b = OpBW'(w_q); end
      S_B1:   begin op_a = OpAW'(evx_q);  op_b = OpBW'(evx_q);  end
      S_B2:   begin op_a = OpAW'(evy_q);  op_b = OpBW'(evy_q);  end
      S_B3:   begin op_a = OpAW'(eyaw_q); op_b = OpBW'(eyaw_q); end
      S_RATE: begin op_a = OpAW'(w_q);    op_b = InvTwoPiQ32;   end
      S_DYAW: begin op_a = OpAW'(rate_q); op_b = $signed(OpBW'(e_q)); end
      S_X:    begin op_a = OpAW'(a_q);    op_b = HalfPiQ30;     end
      S_X2:   begin op_a = OpAW'(x_q);    op_b = OpBW'(x_q);    end
      S_SD72: begin op_a = OpAW'(x2_q);   op_b = $signed(DivM72); end
      S_SD42: begin op_a = OpAW'(m_q);    op_b = $signed(DivM42); end
      S_SD20: begin op_a = OpAW'(m_q);    op_b = $signed(DivM20); end
      S_SD6:  begin op_a = OpAW'(m_q);    op_b = $signed(DivM6);  end
      S_CD90: begin op_a = OpAW'(x2_q);   op_b = $signed(DivM90); end
      S_CD56: begin op_a = OpAW'(m_q);    op_b = $signed(DivM56); end
      S_CD30: begin op_a = OpAW'(m_q);    op_b = $signed(DivM30); end
      S_CD12: begin op_a = OpAW'(m_q);    op_b = $signed(DivM12); end
      S_SM42, S_SM20, S_SM6, S_CM56, S_CM30, S_CM12, S_COS: begin
        op_a = OpAW'(x2_q);
        op_b = OpBW'(t_q);
      end
      S_SIN:  begin op_a = OpAW'(x_q);    op_b = OpBW'(t_q);    end
      S_DIST: begin op_a = OpAW'(v_q);    op_b = $signed(OpBW'(e_q)); end
      S_PX:   begin op_a = OpAW'(dist_q); op_b = OpBW'(co_q);   end
      S_PY:   begin op_a = OpAW'(dist_q); op_b = OpBW'(si_q);   end
      S_JL1:  begin op_a = OpAW'(rl_q);   op_b = PiOver30Q32;   end
      S_JR1:  begin op_a = OpAW'(rr_q);   op_b = PiOver30Q32;   end
      S_JL2, S_JR2: begin op_a = OpAW'(j_q); op_b = $signed(OpBW'(e_q)); end
      S_VX:   begin op_a = $signed(OpAW'(bvx_q)); op_b = $signed(OpBW'(e_q)); end
      S_VY:   begin op_a = $signed(OpAW'(bvy_q)); op_b = $signed(OpBW'(e_q)); end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: if (item_valid_i) state_d = B_MUL1;
      B_MUL1: state_d = B_MUL2;
      B_MUL2: state_d = B_WB;
      B_WB:   state_d = last_step ? B_OUT : B_MUL1;
      B_OUT:  if (!out_valid_q || out_ready_i) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o    = 1'b0;
    mctl     = '0;
    wb_en    = 1'b0;
    out_load = 1'b0;
    case (state_q)
      B_IDLE: pop_o = item_valid_i;
      B_MUL1: mctl.lo = 1'b1;
      B_MUL2: mctl.hi = 1'b1;
      B_WB:   wb_en = 1'b1;
      B_OUT:  out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      step_q      <= S_VL;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        step_q <= S_VL;
      end else if (wb_en && !last_step) begin
        step_q <= step_e'(step_q + 1'b1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // write-back helpers
  assign vr_w    = sat32(r12);
  assign vsum    = 33'(vl_q) + 33'(vr_w);
  assign yaw_new = yaw_q + r24[31:0];
  assign yaw_sh  = yaw_new + 32'h2000_0000;
  assign cval    = 32'(OneQ30 - (r30 >>> 1));
  assign sum_vx  = prod_t'($signed({1'b0, varx_q})) + r20;
  assign sum_vy  = prod_t'($signed({1'b0, vary_q})) + r20;

  // working registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rl_q   <= item_i.left_rpm;
      rr_q   <= item_i.right_rpm;
      e_q    <= item_i.elapsed;
      zero_q <= item_i.zero_dt;
    end
    if (wb_en) begin
      case (step_q)
        S_VL: vl_q <= sat32(r12);
        S_VR: begin
          v_q    <= vsum[32:1];
          dsat_q <= sat32(prod_t'(vr_w) - prod_t'(vl_q));
        end
        S_W:  w_q <= sat32(r24);
        S_E1, S_E4: et_q <= r24[39:0];
        S_E2: evx_q  <= sat32(prod_t'(et_q) + r24 + OfsVx);
        S_E3: evy_q  <= sat32(r24);
        S_E5: eyaw_q <= sat32(prod_t'(et_q) + r24 + OfsYaw);
        S_B1: bvx_q  <= r24[38:0];
        S_B2: bvy_q  <= r24[38:0];
        S_B3: byaw_q <= r24[38:0];
        S_RATE: rate_q <= r20[41:0];
        S_DYAW: begin
          a_q   <= $signed({1'b0, yaw_sh[29:0]}) - 31'sd536870912;
          oct_q <= yaw_sh[31:30];
        end
        S_X:  x_q  <= r30[30:0];
        S_X2: x2_q <= r30[30:0];
        S_SD72, S_CD90: t_q <= 32'(OneQ30 - (p >>> 38));
        S_SD42, S_CD56: t_q <= 32'(OneQ30 - (p >>> 37));
        S_SD20, S_CD30: t_q <= 32'(OneQ30 - (p >>> 36));
        S_CD12:         t_q <= 32'(OneQ30 - (p >>> 35));
        S_SD6:          t_q <= 32'(OneQ30 - (p >>> 34));
        S_SM42, S_SM20, S_SM6, S_CM56, S_CM30, S_CM12: m_q <= r30[30:0];
        S_SIN: s_q <= r30[31:0];
        S_COS: begin
          case (oct_q)
            2'd0:    begin co_q <= cval;  si_q <= s_q;   end
            2'd1:    begin co_q <= -s_q;  si_q <= cval;  end
            2'd2:    begin co_q <= -cval; si_q <= -s_q;  end
            default: begin co_q <= s_q;   si_q <= -cval; end
          endcase
        end
        S_DIST: dist_q <= r20[32:0];
        S_JL1, S_JR1: j_q <= r12[33:0];
        default: ;
      endcase
    end
  end

  // persistent odometry state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xacc_q <= '0;
      yacc_q <= '0;
      yaw_q  <= '0;
      varx_q <= '0;
      vary_q <= '0;
      lang_q <= '0;
      rang_q <= '0;
    end else if (wb_en) begin
      case (step_q)
        S_DYAW: yaw_q  <= yaw_new;
        S_PX:   xacc_q <= sat48(prod_t'(xacc_q) + r30);
        S_PY:   yacc_q <= sat48(prod_t'(yacc_q) + r30);
        S_JL2:  lang_q <= sat48(prod_t'(lang_q) + r20);
        S_JR2:  rang_q <= sat48(prod_t'(rang_q) + r20);
        S_VX:   varx_q <= (sum_vx > Max48U) ? '1 : sum_vx[47:0];
        S_VY:   vary_q <= (sum_vy > Max48U) ? '1 : sum_vy[47:0];
        default: ;
      endcase
    end
  end

  assign slow_v = (v_q >= -SlowQ24) && (v_q <= SlowQ24);
  assign slow_w = (w_q >= -SlowQ24) && (w_q <= SlowQ24);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q.pos_x         <= xacc_q;
      res_q.pos_y         <= yacc_q;
      res_q.heading       <= yaw_q;
      res_q.lin_vel       <= v_q;
      res_q.yaw_rate      <= w_q;
      res_q.var_x         <= varx_q;
      res_q.var_y         <= vary_q;
      res_q.twist_var_vx  <= slow_v ? FloorQ32 : 48'(bvx_q);
      res_q.twist_var_vy  <= slow_w ? FloorQ32 : 48'(bvy_q);
      res_q.twist_var_yaw <= slow_w ? FloorQ32 : 48'(byaw_q);
      res_q.joint_left    <= lang_q;
      res_q.joint_right   <= rang_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

>>> rtl/tracked_odometry_integrator.sv
// Top level of the tracked-vehicle odometry integrator.
// Each item passes the front register and the queue, then 40 micro-steps of the back end
//   (each through B_MUL1, B_MUL2, B_WB) on the shared two-half multiplier, then the result register;
//   an item with zero elapsed time stops after S_B3 and skips the integration steps.
// The back end takes one item at a time; the front register and queue can take items meanwhile.
// Reset: rst_ni is asynchronous, active low; it zeroes the odometry state, empties the
//   queue and loads the configuration reset values. No clearing pass is needed.
module tracked_odometry_integrator #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] left_rpm_i,
  input  logic signed [15:0] right_rpm_i,
  input  logic [19:0]        elapsed_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [47:0] pos_x_o,
  output logic signed [47:0] pos_y_o,
  output logic [31:0]        heading_o,
  output logic signed [31:0] lin_vel_o,
  output logic signed [31:0] yaw_rate_o,
  output logic [47:0]        var_x_o,
  output logic [47:0]        var_y_o,
  output logic [47:0]        twist_var_vx_o,
  output logic [47:0]        twist_var_vy_o,
  output logic [47:0]        twist_var_yaw_o,
  output logic signed [47:0] joint_left_o,
  output logic signed [47:0] joint_right_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import todi_pkg::*;

  cfg_t    cfg;
  item_t   front_item, q_item;
  logic    push, q_ready, q_valid, pop;
  result_t res;

  // register file, read live by the back end (user: write only while idle; not enforced)
  todi_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // front: one input register, tags zero-elapsed items
  todi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .left_rpm_i  (left_rpm_i),
    .right_rpm_i (right_rpm_i),
    .elapsed_i   (elapsed_i),
    .push_o      (push),
    .q_ready_i   (q_ready),
    .item_o      (front_item)
  );

  // decoupling queue
  todi_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (q_ready),
    .item_i  (front_item),
    .valid_o (q_valid),
    .pop_i   (pop),
    .item_o  (q_item)
  );

  // back: sequencer, multiplier, odometry state and result register
  todi_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (res)
  );

  assign pos_x_o         = res.pos_x;
  assign pos_y_o         = res.pos_y;
  assign heading_o       = res.heading;
  assign lin_vel_o       = res.lin_vel;
  assign yaw_rate_o      = res.yaw_rate;
  assign var_x_o         = res.var_x;
  assign var_y_o         = res.var_y;
  assign twist_var_vx_o  = res.twist_var_vx;
  assign twist_var_vy_o  = res.twist_var_vy;
  assign twist_var_yaw_o = res.twist_var_yaw;
  assign joint_left_o    = res.joint_left;
  assign joint_right_o   = res.joint_right;

endmodule

>>> rtl/todi_checker.sv
// Port-level checker for the odometry integrator, bound to the top level.
module todi_checker #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [47:0] pos_x_o,
  input logic [31:0]        heading_o,
  input logic [47:0]        var_x_o
);

  logic [7:0]  pending_q;
  logic [47:0] last_varx_q;
  logic        in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // items inside the block: front register, queue, back end, result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      last_varx_q <= '0;
    end else begin
      pending_q <= pending_q + 8'(in_acc) - 8'(out_acc);
      if (out_acc) last_varx_q <= var_x_o;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pos_x_o) && $stable(heading_o))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != '0)
    else $error("result without a pending item");

  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 8'(QUEUE_DEPTH + 3))
    else $error("more items in flight than storage allows");

  a_varx_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> var_x_o >= last_varx_q)
    else $error("x variance decreased");

endmodule

bind tracked_odometry_integrator todi_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_todi_checker (.*);

>>> dv/tb_tracked_odometry_integrator.sv
// Self-checking testbench for the tracked-vehicle odometry integrator.
`timescale 1ns / 1ps

module tb_tracked_odometry_integrator;
  import todi_pkg::*;

  // One speed report: sprocket speeds and time step.
  typedef struct {
    logic signed [15:0] lrpm;
    logic signed [15:0] rrpm;
    logic [19:0]        dt;
  } speed_item_t;

  localparam longint Max48S = 64'sh7FFF_FFFF_FFFF;
  localparam longint Min48S = -Max48S - 1;
  localparam longint Max48U = 64'sh FFFF_FFFF_FFFF;
  localparam longint InvTwoPi = 683565276;   // 1/(2 pi), Q0.32
  localparam longint HalfPi   = 1686629713;  // pi/2, Q1.30
  localparam longint PiBy30   = 449767923;   // rpm to rad/s, Q0.32
  localparam longint OneQ30   = 64'sd1 <<< 30;
  localparam longint VxOffset = 32212;
  localparam longint YawOffset = 1342;
  localparam longint SlowLimit = 83886;
  localparam longint TwistFloor = 429497;
  localparam int     WatchdogLimit = 20000;
  localparam int     HoldCycles = 1500;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] left_rpm_i = '0;
  logic signed [15:0] right_rpm_i = '0;
  logic [19:0] elapsed_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [47:0] pos_x_o, pos_y_o, joint_left_o, joint_right_o;
  logic [31:0] heading_o;
  logic signed [31:0] lin_vel_o, yaw_rate_o;
  logic [47:0] var_x_o, var_y_o, twist_var_vx_o, twist_var_vy_o, twist_var_yaw_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  tracked_odometry_integrator uut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .left_rpm_i, .right_rpm_i, .elapsed_i,
    .out_valid_o, .out_ready_i, .pos_x_o, .pos_y_o, .heading_o, .lin_vel_o,
    .yaw_rate_o, .var_x_o, .var_y_o, .twist_var_vx_o, .twist_var_vy_o,
    .twist_var_yaw_o, .joint_left_o, .joint_right_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Pending speed reports, expected odometry results, error count.
  speed_item_t pending_q[$];
  result_t     odom_q[$];
  int          err_cnt = 0;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;

  // Shadow of the register file and of the integrator state.
  logic [31:0] reg_shadow [8];
  longint      x_pos = 0, y_pos = 0, var_x_acc = 0, var_y_acc = 0;
  longint      left_ang = 0, right_ang = 0;
  logic [31:0] yaw_ang = '0;

  // ---------------- arithmetic helpers ----------------
  // Round half up, then floor shift (>>> on a signed longint floors).
  function automatic longint rshr(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint clip32(longint v);
    return clip(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic longint qmul30(longint a, longint b);
    return rshr(a * b, 30);
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint ureg(reg_idx_e idx);
    return longint'({32'b0, reg_shadow[idx]});
  endfunction

  function automatic longint sreg(reg_idx_e idx);
    return longint'(signed'(reg_shadow[idx]));
  endfunction

  // Polynomial cos/sin of a binary angle, octant reduced, Q2.30.
  task automatic trig(input logic [31:0] ang, output longint co, output longint si);
    logic [31:0] sh;
    longint a, x, x2, t, s, c;
    sh = ang + 32'h2000_0000;
    a = longint'({34'b0, sh[29:0]}) - 64'sh2000_0000;
    x = rshr(a * HalfPi, 30);
    x2 = qmul30(x, x);
    t = OneQ30 - x2 / 72;
    t = OneQ30 - qmul30(x2, t) / 42;
    t = OneQ30 - qmul30(x2, t) / 20;
    t = OneQ30 - qmul30(x2, t) / 6;
    s = qmul30(x, t);
    t = OneQ30 - x2 / 90;
    t = OneQ30 - qmul30(x2, t) / 56;
    t = OneQ30 - qmul30(x2, t) / 30;
    t = OneQ30 - qmul30(x2, t) / 12;
    c = OneQ30 - qmul30(x2, t) / 2;
    case (sh[31:30])
      2'd0: begin co = c;  si = s;  end
      2'd1: begin co = -s; si = c;  end
      2'd2: begin co = -c; si = -s; end
      default: begin co = s; si = -c; end
    endcase
  endtask

  // Advance the odometry shadow by one speed report and give the expected result.
  task automatic integrate_report(input speed_item_t it, output result_t r);
    longint rl, rr, dt, vl, vr, v, w, dyaw, co, si, travel;
    longint evx, evy, eyaw, bvx, bvy, byaw;
    rl = longint'(it.lrpm);
    rr = longint'(it.rrpm);
    dt = longint'({44'b0, it.dt});
    vl = clip32(rshr(rl * ureg(REG_LEFT_SCALE), 12));
    vr = clip32(rshr(rr * ureg(REG_RIGHT_SCALE), 12));
    v = (vl + vr) >>> 1;
    w = clip32(rshr(clip32(vr - vl) * ureg(REG_YAW_GAIN), 24));
    dyaw = rshr(rshr(w * InvTwoPi, 20) * dt, 24);
    yaw_ang = yaw_ang + dyaw[31:0];
    trig(yaw_ang, co, si);
    travel = rshr(v * dt, 20);
    x_pos = clip(x_pos + rshr(travel * co, 30), Min48S, Max48S);
    y_pos = clip(y_pos + rshr(travel * si, 30), Min48S, Max48S);
    left_ang = clip(left_ang + rshr(rshr(rl * PiBy30, 12) * dt, 20), Min48S, Max48S);
    right_ang = clip(right_ang + rshr(rshr(rr * PiBy30, 12) * dt, 20), Min48S, Max48S);
    evx = clip32(rshr(sreg(REG_A_VX_SPEED) * v, 24) + rshr(sreg(REG_A_VX_TURN) * w, 24)
                 + VxOffset);
    evy = clip32(rshr(sreg(REG_A_VY_TURN) * w, 24));
    eyaw = clip32(rshr(sreg(REG_A_YAW_SPEED) * v, 24) + rshr(sreg(REG_A_YAW_TURN) * w, 24)
                  + YawOffset);
    bvx = rshr(evx * evx, 24);
    bvy = rshr(evy * evy, 24);
    byaw = rshr(eyaw * eyaw, 24);
    var_x_acc = clip(var_x_acc + rshr(bvx * dt, 20), 0, Max48U);
    var_y_acc = clip(var_y_acc + rshr(bvy * dt, 20), 0, Max48U);
    r.pos_x = x_pos[47:0];
    r.pos_y = y_pos[47:0];
    r.heading = yaw_ang;
    r.lin_vel = v[31:0];
    r.yaw_rate = w[31:0];
    r.var_x = var_x_acc[47:0];
    r.var_y = var_y_acc[47:0];
    r.twist_var_vx = abs64(v) <= SlowLimit ? TwistFloor[47:0] : bvx[47:0];
    r.twist_var_vy = abs64(w) <= SlowLimit ? TwistFloor[47:0] : bvy[47:0];
    r.twist_var_yaw = abs64(w) <= SlowLimit ? TwistFloor[47:0] : byaw[47:0];
    r.joint_left = left_ang[47:0];
    r.joint_right = right_ang[47:0];
  endtask

  // ---------------- checking ----------------
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      report_mismatch(what, got, want);
    end
  endtask

  // ---------------- driver ----------------
  speed_item_t offered;

  always @(posedge clk_i) begin
    result_t r;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        integrate_report(offered, r);
        odom_q.insert(odom_q.size(), r);
      end
      // Hold the offered item until it is taken; otherwise maybe offer the next one.
      if (!(in_valid_i && !in_ready_o)) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          offered = pending_q.pop_front();
          in_valid_i <= 1'b1;
          left_rpm_i <= offered.lrpm;
          right_rpm_i <= offered.rrpm;
          elapsed_i <= offered.dt;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------- long receiver hold-off ----------------
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_cnt = 0;
  wire  hold_active = hold_req && !hold_done;

  always @(posedge clk_i) begin
    if (hold_active) begin
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt == HoldCycles) begin
        hold_done <= 1'b1;
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (odom_q.size() == 0) begin
          report_mismatch("result with nothing expected", '0, '0);
        end else begin
          e = odom_q.pop_front();
          check_field("pos_x", pos_x_o, e.pos_x);
          check_field("pos_y", pos_y_o, e.pos_y);
          check_field("heading", heading_o, e.heading);
          check_field("lin_vel", lin_vel_o, e.lin_vel);
          check_field("yaw_rate", yaw_rate_o, e.yaw_rate);
          check_field("var_x", var_x_o, e.var_x);
          check_field("var_y", var_y_o, e.var_y);
          check_field("twist_var_vx", twist_var_vx_o, e.twist_var_vx);
          check_field("twist_var_vy", twist_var_vy_o, e.twist_var_vy);
          check_field("twist_var_yaw", twist_var_yaw_o, e.twist_var_yaw);
          check_field("joint_left", joint_left_o, e.joint_left);
          check_field("joint_right", joint_right_o, e.joint_right);
        end
      end
      out_ready_i <= hold_active ? 1'b0 : ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // ---------------- watchdog: cycles with no handshake on either side ----------------
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic reg_write(reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    reg_shadow[idx] = val;
  endtask

  task automatic write_all(logic [31:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      reg_write(reg_idx_e'(i), vals[i]);
    end
  endtask

  task automatic push(int l, int r, int dt);
    speed_item_t it;
    it.lrpm = l[15:0];
    it.rrpm = r[15:0];
    it.dt = dt[19:0];
    pending_q.insert(pending_q.size(), it);
  endtask

  // Mostly plausible driving, some slow and turning-in-place cases, some raw noise.
  task automatic push_random(int n);
    int kind, base, dt;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(9);
      case ($urandom_range(7))
        0: dt = 0;
        1: dt = 20'hFFFFF;
        2: dt = $urandom_range(20'hFFFFF);
        default: dt = $urandom_range(60000, 2000);
      endcase
      if (kind < 3) begin
        push($urandom, $urandom, dt);
      end else if (kind < 5) begin
        // Near the slow thresholds.
        push($signed($urandom_range(700)) - 350, $signed($urandom_range(700)) - 350, dt);
      end else if (kind < 7) begin
        base = $signed($urandom_range(20000)) - 10000;
        push(base, -base + $signed($urandom_range(200)) - 100, dt);
      end else begin
        base = $signed($urandom_range(60000)) - 30000;
        push(base, base + $signed($urandom_range(4000)) - 2000, dt);
      end
    end
  endtask

  // Wait until every item has gone out and its result is back, then let the block settle.
  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || odom_q.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (150) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] cfg_vals [8];
    reg_shadow = '{RstLeftScale, RstRightScale, RstYawGain, RstAVxSpeed, RstAVxTurn,
                   RstAVyTurn, RstAYawSpeed, RstAYawTurn};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Defaults, written back explicitly; directed corners, no idling.
    cfg_vals = reg_shadow;
    write_all(cfg_vals);
    push(0, 0, 0);
    push(32767, 32767, 20'hFFFFF);
    push(-32768, -32768, 20'hFFFFF);
    push(32767, -32768, 20'hFFFFF);
    push(-32768, 32767, 20'hFFFFF);
    push(-32768, 32767, 0);           // zero elapsed: state holds
    push(299, 299, 40000);            // forward just over the slow floor
    push(300, 300, 40000);            // just over it
    push(-300, -300, 40000);
    push(10, -10, 30000);             // slow turn
    push(-400, 400, 30000);           // turning in place
    push(1, -1, 1);
    push(-1, -1, 20'hFFFFF);
    push(16, 16, 1);
    push(20000, 19000, 500000);
    push(-12000, -13000, 700000);
    push(5555, -5555, 20'h80000);
    push(0, 0, 20'hFFFFF);
    drain();

    push_random(400);
    drain();

    // Upper extremes of every register, sender idles.
    cfg_vals = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    write_all(cfg_vals);
    src_idle_pct = 46;
    push_random(300);
    drain();

    // Lower extremes, receiver stalls.
    cfg_vals = '{32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000};
    write_all(cfg_vals);
    src_idle_pct = 0;
    sink_stall_pct = 46;
    push_random(300);
    drain();

    // Random scales and error coefficients, both sides idle.
    for (int i = 0; i < 8; i++) begin
      cfg_vals[i] = $urandom;
    end
    cfg_vals[REG_LEFT_SCALE] = $urandom_range(4000000);
    cfg_vals[REG_RIGHT_SCALE] = $urandom_range(4000000);
    write_all(cfg_vals);
    src_idle_pct = 16;
    sink_stall_pct = 16;
    push_random(300);
    drain();

    // Back to defaults; receiver holds off long enough for the input to back up.
    cfg_vals = '{RstLeftScale, RstRightScale, RstYawGain, RstAVxSpeed, RstAVxTurn,
                 RstAVyTurn, RstAYawSpeed, RstAYawTurn};
    write_all(cfg_vals);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_req <= 1'b1;
    push_random(330);
    drain();

    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> tracked_odometry_integrator.f
rtl/todi_pkg.sv
rtl/todi_regs.sv
rtl/todi_front.sv
rtl/todi_fifo.sv
rtl/todi_mul.sv
rtl/todi_back.sv
rtl/tracked_odometry_integrator.sv
rtl/todi_checker.sv
dv/tb_tracked_odometry_integrator.sv
